// File: hdl/pid_clamped_step_core_assert.svh
// Assertion macros for the PID step core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef PID_CLAMPED_STEP_CORE_ASSERT_SVH
`define PID_CLAMPED_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pcs_pkg.sv
// Shared types, constants and microcode ROM for the PID step core.
// No dependencies.
`timescale 1ns / 1ps

package pcs_pkg;

    // Register map and reset values
    localparam int PADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_TARGET    = 3'd3,
        REG_STEP_TIME = 3'd4
    } t_reg_idx;

    localparam logic [30:0] GAIN_P_RST    = 31'd78643;
    localparam logic [30:0] GAIN_I_RST    = 31'd26214;
    localparam logic [30:0] GAIN_D_RST    = 31'd3277;
    localparam logic [31:0] TARGET_RST    = 32'd1441792;
    localparam logic [30:0] STEP_TIME_RST = 31'd6554;

    // Arithmetic limits
    localparam logic [31:0] INTEG_CLAMP = 32'd6553600;
    localparam logic [16:0] DRIVE_MAX   = 17'h10000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;

    // Divider: quotient bits produced one per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_ABS,
        DV_CHK,
        DV_RUN,
        DV_FIX
    } t_div_state;

    // Microcode
    localparam int UC_STEP_W = 4;

    typedef enum logic [1:0] {
        MA_ERR,
        MA_INTEG,
        MA_DERIV
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_DT,
        MB_KP,
        MB_KI,
        MB_KD
    } t_mul_b;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_INPUT,
        JC_DT_ZERO,
        JC_DIV_BUSY,
        JC_OUT_BLOCKED
    } t_jcond;

    typedef struct packed {
        logic                 take;
        logic                 mul_en;
        t_mul_a               mul_a;
        t_mul_b               mul_b;
        logic                 integ_en;
        logic                 div_start;
        logic                 acc_en;
        logic                 acc_load;
        logic                 commit;
        logic                 zero_drive;
        t_jcond               jcond;
        logic [UC_STEP_W-1:0] jtarget;
    } t_ucw;

    typedef struct packed {
        logic no_input;
        logic dt_zero;
        logic div_busy;
        logic out_blocked;
    } t_ustat;

    localparam logic [UC_STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [UC_STEP_W-1:0] S_START  = 4'd1;
    localparam logic [UC_STEP_W-1:0] S_INTEG  = 4'd2;
    localparam logic [UC_STEP_W-1:0] S_ACC_P  = 4'd3;
    localparam logic [UC_STEP_W-1:0] S_ACC_I  = 4'd4;
    localparam logic [UC_STEP_W-1:0] S_WAIT   = 4'd5;
    localparam logic [UC_STEP_W-1:0] S_MUL_D  = 4'd6;
    localparam logic [UC_STEP_W-1:0] S_ACC_D  = 4'd7;
    localparam logic [UC_STEP_W-1:0] S_COMMIT = 4'd8;
    localparam logic [UC_STEP_W-1:0] S_RET    = 4'd9;
    localparam logic [UC_STEP_W-1:0] S_ZERO   = 4'd10;
    localparam logic [UC_STEP_W-1:0] S_ZRET   = 4'd11;

    function automatic t_ucw ucode_rom(input logic [UC_STEP_W-1:0] step);
        t_ucw w;
        w = '0;
        w.jcond = JC_NEVER;
        unique case (step)
            S_IDLE: begin
                w.take    = 1'b1;
                w.jcond   = JC_NO_INPUT;
                w.jtarget = S_IDLE;
            end
            S_START: begin
                w.mul_en    = 1'b1;
                w.mul_a     = MA_ERR;
                w.mul_b     = MB_DT;
                w.div_start = 1'b1;
                w.jcond     = JC_DT_ZERO;
                w.jtarget   = S_ZERO;
            end
            S_INTEG: begin
                w.integ_en = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_ERR;
                w.mul_b    = MB_KP;
            end
            S_ACC_P: begin
                w.acc_en   = 1'b1;
                w.acc_load = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_INTEG;
                w.mul_b    = MB_KI;
            end
            S_ACC_I: begin
                w.acc_en = 1'b1;
            end
            S_WAIT: begin
                w.jcond   = JC_DIV_BUSY;
                w.jtarget = S_WAIT;
            end
            S_MUL_D: begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DERIV;
                w.mul_b  = MB_KD;
            end
            S_ACC_D: begin
                w.acc_en = 1'b1;
            end
            S_COMMIT: begin
                w.commit  = 1'b1;
                w.jcond   = JC_OUT_BLOCKED;
                w.jtarget = S_COMMIT;
            end
            S_ZERO: begin
                w.commit     = 1'b1;
                w.zero_drive = 1'b1;
                w.jcond      = JC_OUT_BLOCKED;
                w.jtarget    = S_ZERO;
            end
            S_RET, S_ZRET: begin
                w.jcond   = JC_ALWAYS;
                w.jtarget = S_IDLE;
            end
            default: begin
                w.jcond   = JC_ALWAYS;
                w.jtarget = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hdl/pid_clamped_step_core.sv
// PID step core top level: register port, sequencer, divider, datapath,
// output register. Depends on pcs_pkg, pcs_useq, pcs_div, pcs_dpath.
`timescale 1ns / 1ps
`include "pid_clamped_step_core_assert.svh"

// Usage
//  Input channel: i_in_valid / o_in_stall carry one measurement word
//  (signed Q16.16). Output channel: o_out_valid / i_out_stall carry
//  o_drive (0..1.0, Q16.16) and o_error_value. A word moves on a rising
//  edge with valid high and stall low.
//  Flow: one item at a time. A word is taken only when the sequencer is
//  at its idle step; it then steps through the products and the sums,
//  waits for the restoring divider of the derivative, which makes one
//  quotient bit per cycle over 32 bits between its setup and fix-up
//  steps, and commits the result. A quotient of 2^32 or more skips
//  those 32 bits. With zero step time the divider is not started, the
//  sequencer jumps to its zero step, a zero drive is committed and
//  state is not touched.
//  The result waits in an output register; the core is free to take the
//  next word while it waits, and only stalls at its own commit step if
//  the previous result has not gone.
//  Reset (synchronous, active low) restores the register defaults and
//  clears the integral and the stored error.
//  Registers (APB, 4-byte stride): gain_p, gain_i, gain_d, target,
//  step_time. Write them only while the core is idle.

module pid_clamped_step_core #(
    parameter logic [31:0] INTEG_CLAMP = pcs_pkg::INTEG_CLAMP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [31:0]           i_measurement,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic        [16:0]           o_drive,
    output logic signed [31:0]           o_error_value
);

    // configuration registers
    logic [30:0]        r_gain_p;
    logic [30:0]        r_gain_i;
    logic [30:0]        r_gain_d;
    logic signed [31:0] r_target;
    logic [30:0]        r_step_time;

    // result register
    logic               r_out_valid;
    logic [16:0]        r_drive;
    logic signed [31:0] r_err_out;

    pcs_pkg::t_ucw      ucw;
    pcs_pkg::t_ustat    ustat;
    pcs_pkg::t_reg_idx  reg_idx;

    logic               cfg_we;
    logic               in_accept;
    logic               out_blocked;
    logic               commit_fire;
    logic               div_busy;
    logic signed [31:0] div_quot;
    logic signed [32:0] dp_diff;
    logic signed [31:0] dp_err;
    logic [16:0]        dp_drive;

    // ---- APB register port ----
    assign pready  = 1'b1;
    assign reg_idx = pcs_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            pcs_pkg::REG_GAIN_P:    prdata = {1'b0, r_gain_p};
            pcs_pkg::REG_GAIN_I:    prdata = {1'b0, r_gain_i};
            pcs_pkg::REG_GAIN_D:    prdata = {1'b0, r_gain_d};
            pcs_pkg::REG_TARGET:    prdata = r_target;
            pcs_pkg::REG_STEP_TIME: prdata = {1'b0, r_step_time};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= pcs_pkg::GAIN_P_RST;
            r_gain_i    <= pcs_pkg::GAIN_I_RST;
            r_gain_d    <= pcs_pkg::GAIN_D_RST;
            r_target    <= pcs_pkg::TARGET_RST;
            r_step_time <= pcs_pkg::STEP_TIME_RST;
        end else if (cfg_we) begin
            unique case (reg_idx)
                pcs_pkg::REG_GAIN_P:    r_gain_p    <= pwdata[30:0];
                pcs_pkg::REG_GAIN_I:    r_gain_i    <= pwdata[30:0];
                pcs_pkg::REG_GAIN_D:    r_gain_d    <= pwdata[30:0];
                pcs_pkg::REG_TARGET:    r_target    <= pwdata;
                pcs_pkg::REG_STEP_TIME: r_step_time <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // ---- handshakes ----
    // stall follows the control word only: the idle step takes a word
    assign o_in_stall  = !ucw.take;
    assign in_accept   = i_in_valid && ucw.take;
    assign out_blocked = r_out_valid && i_out_stall;
    // commit steps loop on themselves while the result register is full and stalled
    assign commit_fire = ucw.commit && !out_blocked;

    assign ustat.no_input    = !i_in_valid;
    assign ustat.dt_zero     = (r_step_time == '0);
    assign ustat.div_busy    = div_busy;
    assign ustat.out_blocked = out_blocked;

    pcs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (ustat),
        .o_ucw   (ucw)
    );

    // divider never started on a zero step time
    pcs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ucw.div_start && !ustat.dt_zero),
        .i_diff    (dp_diff),
        .i_divisor (r_step_time),
        .o_busy    (div_busy),
        .o_quot    (div_quot)
    );

    pcs_dpath #(
        .INTEG_CLAMP (INTEG_CLAMP)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ucw         (ucw),
        .i_take        (in_accept),
        .i_commit      (commit_fire),
        .i_measurement (i_measurement),
        .i_target      (r_target),
        .i_gain_p      (r_gain_p),
        .i_gain_i      (r_gain_i),
        .i_gain_d      (r_gain_d),
        .i_step_time   (r_step_time),
        .i_quot        (div_quot),
        .o_diff        (dp_diff),
        .o_err         (dp_err),
        .o_drive       (dp_drive)
    );

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            r_drive   <= ucw.zero_drive ? '0 : dp_drive;
            r_err_out <= dp_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_error_value = r_err_out;

    // ---- checks ----
    `PCS_ASSERT_NOW(a_commit_div_done, ucw.commit && !ucw.zero_drive, !div_busy, "commit with divider running")
    `PCS_ASSERT_NEXT(a_busy_after_take, in_accept, o_in_stall, "second word taken during an item")
    `PCS_ASSERT_NOW(a_drive_range, o_out_valid, o_drive <= pcs_pkg::DRIVE_MAX, "drive above 1.0")

endmodule

// File: hdl/pcs_useq.sv
// Microcode sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pcs_pkg::t_ustat i_stat,
    output pcs_pkg::t_ucw   o_ucw
);

    logic [pcs_pkg::UC_STEP_W-1:0] r_step;
    logic [pcs_pkg::UC_STEP_W-1:0] n_step;
    logic                          jump;

    assign o_ucw = pcs_pkg::ucode_rom(r_step);

    always_comb begin
        unique case (o_ucw.jcond)
            pcs_pkg::JC_NEVER:       jump = 1'b0;
            pcs_pkg::JC_ALWAYS:      jump = 1'b1;
            pcs_pkg::JC_NO_INPUT:    jump = i_stat.no_input;
            pcs_pkg::JC_DT_ZERO:     jump = i_stat.dt_zero;
            pcs_pkg::JC_DIV_BUSY:    jump = i_stat.div_busy;
            pcs_pkg::JC_OUT_BLOCKED: jump = i_stat.out_blocked;
            default:                 jump = 1'b1;
        endcase
        n_step = jump ? o_ucw.jtarget : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= pcs_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: hdl/pcs_div.sv
// Restoring divider for the derivative: (diff * 2^16) / step_time,
// truncated toward zero and saturated to 32 bits. Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_diff,
    input  logic        [30:0] i_divisor,
    output logic               o_busy,
    output logic signed [31:0] o_quot
);

    pcs_pkg::t_div_state r_state;
    pcs_pkg::t_div_state n_state;

    logic signed [32:0]              r_diff;
    logic                            r_neg;
    logic [31:0]                     r_mag;
    logic [30:0]                     r_rem;
    logic [31:0]                     r_q;
    logic [pcs_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic                            r_ovf;
    logic [31:0]                     r_quot;

    logic [31:0] rem_sh;
    logic [31:0] rem_sub;
    logic        rem_ge;
    logic [30:0] rem_hi;
    logic        hi_ovf;

    assign rem_sh  = {r_rem, r_q[31]};
    assign rem_ge  = rem_sh >= {1'b0, i_divisor};
    assign rem_sub = rem_sh - {1'b0, i_divisor};
    assign rem_hi  = {15'd0, r_mag[31:16]};
    // Quotient of 2^32 or more: saturates whatever the sign
    assign hi_ovf  = rem_hi >= i_divisor;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcs_pkg::DV_IDLE: if (i_start) n_state = pcs_pkg::DV_ABS;
            pcs_pkg::DV_ABS:  n_state = pcs_pkg::DV_CHK;
            pcs_pkg::DV_CHK:  n_state = hi_ovf ? pcs_pkg::DV_FIX : pcs_pkg::DV_RUN;
            pcs_pkg::DV_RUN:  if (r_cnt == '0) n_state = pcs_pkg::DV_FIX;
            pcs_pkg::DV_FIX:  n_state = pcs_pkg::DV_IDLE;
            default:          n_state = pcs_pkg::DV_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != pcs_pkg::DV_IDLE);
        o_quot = r_quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcs_pkg::DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pcs_pkg::DV_IDLE: begin
                if (i_start) r_diff <= i_diff;
            end
            pcs_pkg::DV_ABS: begin
                r_neg <= r_diff[32];
                r_mag <= r_diff[32] ? 32'(-r_diff) : r_diff[31:0];
            end
            pcs_pkg::DV_CHK: begin
                r_rem <= rem_hi;
                r_q   <= {r_mag[15:0], 16'd0};
                r_ovf <= hi_ovf;
                r_cnt <= pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_STEPS - 1);
            end
            pcs_pkg::DV_RUN: begin
                r_rem <= rem_ge ? rem_sub[30:0] : rem_sh[30:0];
                r_q   <= {r_q[30:0], rem_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            pcs_pkg::DV_FIX: begin
                if (r_ovf) begin
                    r_quot <= r_neg ? pcs_pkg::Q_MIN : pcs_pkg::Q_MAX;
                end else if (r_neg) begin
                    r_quot <= (r_q > pcs_pkg::Q_MIN) ? pcs_pkg::Q_MIN : -r_q;
                end else begin
                    r_quot <= r_q[31] ? pcs_pkg::Q_MAX : r_q;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/pcs_dpath.sv
// PID datapath: error, shared multiplier, integral clamp, accumulator,
// controller state. Driven by the control word. Depends on pcs_pkg.
`timescale 1ns / 1ps

module pcs_dpath #(
    parameter logic [31:0] INTEG_CLAMP = pcs_pkg::INTEG_CLAMP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcs_pkg::t_ucw      i_ucw,
    input  logic               i_take,
    input  logic               i_commit,
    input  logic signed [31:0] i_measurement,
    input  logic signed [31:0] i_target,
    input  logic        [30:0] i_gain_p,
    input  logic        [30:0] i_gain_i,
    input  logic        [30:0] i_gain_d,
    input  logic        [30:0] i_step_time,
    input  logic signed [31:0] i_quot,
    output logic signed [32:0] o_diff,
    output logic signed [31:0] o_err,
    output logic        [16:0] o_drive
);

    localparam logic signed [48:0] LIM_HI  = 49'(INTEG_CLAMP);
    localparam logic signed [48:0] LIM_LO  = -LIM_HI;
    localparam logic signed [49:0] ACC_MAX = 50'(pcs_pkg::DRIVE_MAX);

    logic signed [31:0] r_err;
    logic signed [31:0] r_integral;
    logic signed [31:0] r_last_err;
    logic signed [31:0] r_integ;
    logic signed [63:0] r_prod;
    logic signed [49:0] r_acc;

    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [47:0] prod_q;
    logic signed [49:0] prod_ext;
    logic signed [48:0] integ_sum;
    logic signed [48:0] integ_clip;

    // target - measurement, saturated on signed overflow
    assign err_wide = {i_target[31], i_target} - {i_measurement[31], i_measurement};
    assign err_sat  = (err_wide[32] != err_wide[31])
                    ? (err_wide[32] ? pcs_pkg::Q_MIN : pcs_pkg::Q_MAX)
                    : err_wide[31:0];

    // product floored to Q16.16
    assign prod_q   = r_prod[63:16];
    assign prod_ext = {{2{prod_q[47]}}, prod_q};

    assign integ_sum = {{17{r_integral[31]}}, r_integral} + {prod_q[47], prod_q};

    always_comb begin
        if (integ_sum > LIM_HI) begin
            integ_clip = LIM_HI;
        end else if (integ_sum < LIM_LO) begin
            integ_clip = LIM_LO;
        end else begin
            integ_clip = integ_sum;
        end
    end

    always_comb begin
        unique case (i_ucw.mul_a)
            pcs_pkg::MA_ERR:   mul_a = r_err;
            pcs_pkg::MA_INTEG: mul_a = r_integ;
            pcs_pkg::MA_DERIV: mul_a = i_quot;
            default:           mul_a = r_err;
        endcase
        unique case (i_ucw.mul_b)
            pcs_pkg::MB_DT: mul_b = {1'b0, i_step_time};
            pcs_pkg::MB_KP: mul_b = {1'b0, i_gain_p};
            pcs_pkg::MB_KI: mul_b = {1'b0, i_gain_i};
            pcs_pkg::MB_KD: mul_b = {1'b0, i_gain_d};
            default:        mul_b = {1'b0, i_gain_p};
        endcase
    end

    // command clamp to 0..1.0
    always_comb begin
        if (r_acc[49]) begin
            o_drive = '0;
        end else if (r_acc > ACC_MAX) begin
            o_drive = pcs_pkg::DRIVE_MAX;
        end else begin
            o_drive = r_acc[16:0];
        end
    end

    assign o_err  = r_err;
    assign o_diff = {r_err[31], r_err} - {r_last_err[31], r_last_err};

    always_ff @(posedge i_clk) begin
        if (i_take) r_err <= err_sat;
        if (i_ucw.mul_en) r_prod <= mul_a * mul_b;
        if (i_ucw.integ_en) r_integ <= integ_clip[31:0];
        if (i_ucw.acc_en) begin
            r_acc <= i_ucw.acc_load ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else if (i_commit && !i_ucw.zero_drive) begin
            r_integral <= r_integ;
            r_last_err <= r_err;
        end
    end

endmodule

// File: test/pid_clamped_step_core_tb.sv
// Testbench for pid_clamped_step_core: directed and random measurement words
// checked against an in-bench fixed-point PID predictor, with APB setup.
// Depends on pcs_pkg and the core RTL only.
`timescale 1ns / 1ps

module pid_clamped_step_core_tb;

    // Watchdog: cycles with no word, register write or result accepted.
    // The worst legal quiet spell is the output hold-off plus the core's
    // own run time for its items, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to let the sequencer get back to idle after the last result
    localparam int SETTLE_CYCLES  = 8;
    // Hold-off used to fill the core and back up the input side
    localparam int HOLD_OFF_CYCLES = 600;

    // Register slots past the end of the map; writes must be dropped
    localparam logic [2:0] REG_PAST_END  = 3'd5;
    localparam logic [2:0] REG_LAST_SLOT = 3'd7;

    typedef struct packed {
        logic [16:0]        drive;
        logic signed [31:0] error_value;
    } t_pid_word;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [pcs_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [31:0]          i_measurement;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [16:0]                 o_drive;
    logic signed [31:0]          o_error_value;

    // Predictor copy of the registers and the controller state
    logic [30:0]        kp_q;
    logic [30:0]        ki_q;
    logic [30:0]        kd_q;
    logic signed [31:0] setpoint_q;
    logic [30:0]        dt_q;
    logic signed [31:0] integ_q;
    logic signed [31:0] err_prev;

    t_pid_word expected_words[$];
    int        n_mismatch;
    int        quiet_cycles;
    bit        tx_gaps;
    bit        rx_gaps;
    int        rx_hold_cycles;

    pid_clamped_step_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_measurement (i_measurement),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive       (o_drive),
        .o_error_value (o_error_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint sat_q32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (v < -longint'(64'sd2147483648)) return -longint'(64'sd2147483648);
        return v;
    endfunction

    // One controller update. Products are floored to Q16.16 with an
    // arithmetic shift; the derivative quotient truncates towards zero.
    // Zero step time leaves integral and last error alone.
    function automatic t_pid_word pid_step_predict(input logic signed [31:0] meas);
        t_pid_word r;
        longint    err;
        longint    integ;
        longint    diff;
        longint    deriv;
        longint    sum;
        longint    lim;
        lim           = longint'(pcs_pkg::INTEG_CLAMP);
        err           = sat_q32(longint'(setpoint_q) - longint'(meas));
        r.error_value = err[31:0];
        r.drive       = '0;
        if (dt_q != '0) begin
            integ = longint'(integ_q) + ((err * longint'(dt_q)) >>> 16);
            if (integ > lim)  integ = lim;
            if (integ < -lim) integ = -lim;
            diff  = err - longint'(err_prev);
            deriv = sat_q32((diff * 64'sd65536) / longint'(dt_q));
            sum   = ((longint'(kp_q) * err) >>> 16)
                  + ((longint'(ki_q) * integ) >>> 16)
                  + ((longint'(kd_q) * deriv) >>> 16);
            if (sum > longint'(pcs_pkg::DRIVE_MAX)) sum = longint'(pcs_pkg::DRIVE_MAX);
            if (sum < 0) sum = 0;
            r.drive  = sum[16:0];
            integ_q  = integ[31:0];
            err_prev = err[31:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: valid and stall are stable mid-cycle, so the word
    // seen at the falling edge is the one taken at the next rising edge.
    // ------------------------------------------------------------------
    initial begin
        t_pid_word want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: drive %0d, error_value %0d",
                           o_drive, o_error_value);
                    n_mismatch++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, o_drive);
                        n_mismatch++;
                    end
                    if (o_error_value !== want.error_value) begin
                        $error("error_value: expected %0d, got %0d",
                               want.error_value, o_error_value);
                        n_mismatch++;
                    end
                end
            end
        end
    end

    // Output stall: random, off, or a long hold-off counted here
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                n              = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_out_stall   <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= rx_gaps && ($urandom_range(99) < 33);
            end
        end
    end

    // Watchdog
    initial begin
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one measurement word; predict when it is taken. Valid stays
    // high on return so a following word goes out back to back.
    task automatic send_measurement(input logic signed [31:0] m);
        bit took;
        if (tx_gaps && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_measurement <= m;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end while (!took);
        expected_words.push_back(pid_step_predict(m));
    endtask

    // Drop valid, wait for every result, let the sequencer reach idle
    task automatic settle_core();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup, access, done once pready is seen
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            pcs_pkg::REG_GAIN_P:    kp_q       = value[30:0];
            pcs_pkg::REG_GAIN_I:    ki_q       = value[30:0];
            pcs_pkg::REG_GAIN_D:    kd_q       = value[30:0];
            pcs_pkg::REG_TARGET:    setpoint_q = value;
            pcs_pkg::REG_STEP_TIME: dt_q       = value[30:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic cfg_all(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [31:0] kd, input logic [31:0] sp,
                           input logic [31:0] dt);
        settle_core();
        cfg_write(pcs_pkg::REG_GAIN_P, kp);
        cfg_write(pcs_pkg::REG_GAIN_I, ki);
        cfg_write(pcs_pkg::REG_GAIN_D, kd);
        cfg_write(pcs_pkg::REG_TARGET, sp);
        cfg_write(pcs_pkg::REG_STEP_TIME, dt);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset: zero error, plain error, both input extremes
    task automatic test_reset_defaults();
        send_measurement(setpoint_q);
        send_measurement(32'sd0);
        send_measurement(pcs_pkg::Q_MAX);
        send_measurement(pcs_pkg::Q_MIN);
    endtask

    // Error saturates both ways; gains and step time at full scale,
    // written with the spare top bit set so it must be dropped
    task automatic test_error_saturation();
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pcs_pkg::Q_MAX,
                32'hFFFF_FFFF);
        send_measurement(pcs_pkg::Q_MIN);
        send_measurement(32'sd0);
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, pcs_pkg::Q_MIN,
                32'hFFFF_FFFF);
        send_measurement(pcs_pkg::Q_MAX);
    endtask

    // Smallest step time: any sizeable change pins the derivative
    task automatic test_derivative_saturation();
        cfg_all(32'd0, 32'd0, 32'd65536, 32'd0, 32'd1);
        send_measurement(32'sh4000_0000);
        send_measurement(-32'sh4000_0000);
        send_measurement(32'sd1);
    endtask

    // Zero step time: drive forced low, state frozen until dt returns
    task automatic test_zero_step_time();
        cfg_all({1'b0, pcs_pkg::GAIN_P_RST}, {1'b0, pcs_pkg::GAIN_I_RST},
                {1'b0, pcs_pkg::GAIN_D_RST}, pcs_pkg::TARGET_RST, 32'd0);
        send_measurement(32'sd0);
        send_measurement(32'sh0030_0000);
        send_measurement(pcs_pkg::Q_MIN);
        settle_core();
        cfg_write(pcs_pkg::REG_STEP_TIME, {1'b0, pcs_pkg::STEP_TIME_RST});
        send_measurement(32'sh0010_0000);
    endtask

    // Writes past the register map must change nothing
    task automatic test_unmapped_write();
        settle_core();
        cfg_write(REG_PAST_END, 32'hFFFF_FFFF);
        cfg_write(REG_LAST_SLOT, 32'hFFFF_FFFF);
        send_measurement(32'sh0014_0000);
        send_measurement(32'sh0018_0000);
    endtask

    // One-second step, error of 200.0: integral hits +100.0, then -100.0
    task automatic test_integral_clamp();
        cfg_all(32'd0, 32'd655, 32'd0, 32'd0, 32'd65536);
        send_measurement(-32'sd13107200);
        send_measurement(-32'sd13107200);
        send_measurement(32'sd13107200);
        send_measurement(32'sd13107200);
        send_measurement(32'sd13107200);
    endtask

    // Output held off for a long spell while words keep coming, so the
    // core fills and pushes back on its input
    task automatic test_backpressure();
        int k;
        cfg_all({1'b0, pcs_pkg::GAIN_P_RST}, {1'b0, pcs_pkg::GAIN_I_RST},
                {1'b0, pcs_pkg::GAIN_D_RST}, pcs_pkg::TARGET_RST,
                {1'b0, pcs_pkg::STEP_TIME_RST});
        tx_gaps        = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (k = 0; k < 20; k++)
            send_measurement(setpoint_q + ($urandom_range(0, 1 << 19) - (1 << 18)));
    endtask

    function automatic logic [31:0] pick_gain();
        unique case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 1 << 17);
        endcase
    endfunction

    function automatic logic [31:0] pick_setpoint();
        unique case ($urandom_range(5))
            0:       return $urandom;
            1:       return pcs_pkg::Q_MAX;
            2:       return pcs_pkg::Q_MIN;
            default: return $urandom_range(0, 200 * 65536) - 100 * 65536;
        endcase
    endfunction

    function automatic logic [31:0] pick_step_time();
        unique case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'h7FFF_FFFF;
            3:       return $urandom;
            default: return $urandom_range(1, 65536);
        endcase
    endfunction

    // Mostly noise around the setpoint, some full-range and edge values
    function automatic logic signed [31:0] pick_measurement();
        unique case ($urandom_range(9))
            6, 7:    return $urandom;
            8:       return $urandom_range(1) ? pcs_pkg::Q_MAX : pcs_pkg::Q_MIN;
            9:       return setpoint_q;
            default: return setpoint_q + ($urandom_range(0, 1 << 19) - (1 << 18));
        endcase
    endfunction

    // Random settings per phase; first phase runs with no idling at all
    task automatic test_random_phases(input int n_phases, input int per_phase);
        int p;
        int k;
        for (p = 0; p < n_phases; p++) begin
            tx_gaps = 1'b0;
            rx_gaps = 1'b0;
            cfg_all(pick_gain(), pick_gain(), pick_gain(), pick_setpoint(),
                    pick_step_time());
            tx_gaps = (p != 0);
            rx_gaps = (p != 0);
            for (k = 0; k < per_phase; k++)
                send_measurement(pick_measurement());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_measurement  = '0;
        n_mismatch     = 0;
        tx_gaps        = 1'b1;
        rx_gaps        = 1'b1;
        rx_hold_cycles = 0;

        // register defaults and cleared state, as after reset
        kp_q       = pcs_pkg::GAIN_P_RST;
        ki_q       = pcs_pkg::GAIN_I_RST;
        kd_q       = pcs_pkg::GAIN_D_RST;
        setpoint_q = pcs_pkg::TARGET_RST;
        dt_q       = pcs_pkg::STEP_TIME_RST;
        integ_q    = '0;
        err_prev   = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_error_saturation();
        test_derivative_saturation();
        test_zero_step_time();
        test_unmapped_write();
        test_integral_clamp();
        test_backpressure();
        test_random_phases(7, 100);

        settle_core();
        repeat (60) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/pcs_pkg.sv
hdl/pcs_useq.sv
hdl/pcs_div.sv
hdl/pcs_dpath.sv
hdl/pid_clamped_step_core.sv
test/pid_clamped_step_core_tb.sv
